>>> rtl/qte_pkg.sv
`timescale 1ns / 1ps
// qte_pkg: shared constants and the CORDIC arctangent table for the
// quaternion to Euler converter. No dependencies.
package qte_pkg;

  localparam int WORK_BITS     = 24;  // components wider than this are floor-shifted
  localparam int NORM_BITS     = 40;  // sum of squares is normalized to this length
  localparam int ACC_FRAC      = 29;  // angle accumulator is Q2.29
  localparam int ZW            = 34;  // angle accumulator width
  localparam int CORDIC_W      = 44;  // CORDIC x/y datapath width
  localparam int INV_GAIN_FRAC = 20;

  localparam logic signed [ZW-1:0] PI_ACC   = ZW'(64'sd1686629713);
  localparam logic [19:0]          INV_GAIN = 20'd636751;  // 1/K in Q0.20

  localparam logic [31:0] ATAN_LOW [10] = '{
    32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
    32'd16771758,  32'd8387925,   32'd4194219,   32'd2097141,  32'd1048575
  };

  // atan(2^-i) in Q2.29; from ten on the angle equals the shift weight
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    if (i < 10) r = ZW'(ATAN_LOW[i]);
    else        r = ZW'(64'sd1 <<< (ACC_FRAC - i));
    return r;
  endfunction

endpackage

>>> rtl/qte_quat_if.sv
`timescale 1ns / 1ps
// qte_quat_if: valid/ready channel carrying one quaternion.
// No dependencies.
interface qte_quat_if #(parameter int COMPONENT_BITS = 16);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_w;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> rtl/qte_euler_if.sv
`timescale 1ns / 1ps
// qte_euler_if: valid/ready channel carrying roll, pitch and yaw.
// No dependencies.
interface qte_euler_if #(parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-2:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

>>> rtl/qte_front.sv
`timescale 1ns / 1ps
// qte_front: four-stage front end: products, matrix terms, leading-one
// search, normalizing shift. Depends on qte_pkg.
module qte_front import qte_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [COMPONENT_BITS-1:0] quat_w,
  input  logic signed [COMPONENT_BITS-1:0] quat_x,
  input  logic signed [COMPONENT_BITS-1:0] quat_y,
  input  logic signed [COMPONENT_BITS-1:0] quat_z,
  output logic                             out_valid,
  output logic signed [CORDIC_W-1:0]       m21,
  output logic signed [CORDIC_W-1:0]       m22,
  output logic signed [CORDIC_W-1:0]       m20,
  output logic signed [CORDIC_W-1:0]       m10,
  output logic signed [CORDIC_W-1:0]       m00
);

  localparam int WB   = (COMPONENT_BITS > WORK_BITS) ? WORK_BITS : COMPONENT_BITS;
  localparam int DROP = COMPONENT_BITS - WB;
  localparam int PW   = 2 * WB;
  localparam int MW   = (PW + 2 > CORDIC_W) ? PW + 2 : CORDIC_W;
  localparam int LENW = $clog2(PW + 2);

  logic [3:0] vld;

  // stage 1: products
  logic signed [WB-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;

  assign qw = WB'(quat_w >>> DROP);
  assign qx = WB'(quat_x >>> DROP);
  assign qy = WB'(quat_y >>> DROP);
  assign qz = WB'(quat_z >>> DROP);

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= qw * qw; xx <= qx * qx; yy <= qy * qy; zz <= qz * qz;
      xy <= qx * qy; xz <= qx * qz; yz <= qy * qz;
      wx <= qw * qx; wy <= qw * qy; wz <= qw * qz;
    end
  end

  // stage 2: sum of squares and unscaled matrix terms
  logic [PW:0]          n2;
  logic signed [MW-1:0] a21, a22, a20, a10, a00;

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= {1'b0, ww} + {1'b0, xx} + {1'b0, yy} + {1'b0, zz};
      a21 <= (MW'(yz) + MW'(wx)) <<< 1;
      a22 <= MW'(ww) - MW'(xx) - MW'(yy) + MW'(zz);
      a20 <= (MW'(xz) - MW'(wy)) <<< 1;
      a10 <= (MW'(xy) + MW'(wz)) <<< 1;
      a00 <= MW'(ww) + MW'(xx) - MW'(yy) - MW'(zz);
    end
  end

  // stage 3: bit length of the sum of squares, turned into a shift
  logic [LENW-1:0]      len;
  logic                 shr;
  logic [5:0]           shamt;
  logic signed [MW-1:0] b21, b22, b20, b10, b00;

  always_comb begin
    len = '0;
    for (int b = 0; b <= PW; b++) begin
      if (n2[b]) len = LENW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shr   <= (int'(len) >= NORM_BITS);
      shamt <= (int'(len) >= NORM_BITS) ? 6'(int'(len) - NORM_BITS)
                                        : 6'(NORM_BITS - int'(len));
      b21 <= a21; b22 <= a22; b20 <= a20; b10 <= a10; b00 <= a00;
    end
  end

  // stage 4: normalize
  function automatic logic signed [CORDIC_W-1:0] norm(input logic signed [MW-1:0] v,
                                                      input logic r,
                                                      input logic [5:0] s);
    logic signed [MW-1:0] t;
    t = r ? (v >>> s) : (v <<< s);
    return t[CORDIC_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m21 <= norm(b21, shr, shamt);
      m22 <= norm(b22, shr, shamt);
      m20 <= norm(b20, shr, shamt);
      m10 <= norm(b10, shr, shamt);
      m00 <= norm(b00, shr, shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];

endmodule

>>> rtl/qte_cordic.sv
`timescale 1ns / 1ps
// qte_cordic: pipelined vectoring CORDIC, one rotation per stage, with a
// sideband that travels alongside. Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
  parameter int STAGES    = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [CORDIC_W-1:0] in_x,
  input  logic signed [CORDIC_W-1:0] in_y,
  input  logic [SIDE_BITS-1:0]       in_side,
  output logic                       out_valid,
  output logic signed [CORDIC_W-1:0] out_x,
  output logic signed [ZW-1:0]       out_z,
  output logic [SIDE_BITS-1:0]       out_side
);

  logic signed [CORDIC_W-1:0] xs   [STAGES+1];
  logic signed [CORDIC_W-1:0] ys   [STAGES+1];
  logic signed [ZW-1:0]       zs   [STAGES+1];
  logic                       zero [STAGES+1];
  logic [SIDE_BITS-1:0]       side [STAGES+1];
  logic                       vld  [STAGES+1];

  // pre-rotation by pi for a negative x term
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (in_x == '0) && (in_y == '0);
      side[0] <= in_side;
      if (in_x < 0) begin
        xs[0] <= -in_x;
        ys[0] <= -in_y;
        zs[0] <= (in_y >= 0) ? PI_ACC : -PI_ACC;
      end else begin
        xs[0] <= in_x;
        ys[0] <= in_y;
        zs[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero[gi+1] <= zero[gi];
        side[gi+1] <= side[gi];
        if (ys[gi] >= 0) begin
          xs[gi+1] <= xs[gi] + (ys[gi] >>> gi);
          ys[gi+1] <= ys[gi] - (xs[gi] >>> gi);
          zs[gi+1] <= zs[gi] + atan_step(gi);
        end else begin
          xs[gi+1] <= xs[gi] - (ys[gi] >>> gi);
          ys[gi+1] <= ys[gi] + (xs[gi] >>> gi);
          zs[gi+1] <= zs[gi] - atan_step(gi);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gi+1] <= 1'b0;
      end else if (en) begin
        vld[gi+1] <= vld[gi];
      end
    end
  end

  // atan2(0, 0) is defined as zero; x stays zero on its own
  assign out_valid = vld[STAGES];
  assign out_x     = xs[STAGES];
  assign out_z     = zero[STAGES] ? '0 : zs[STAGES];
  assign out_side  = side[STAGES];

endmodule

>>> rtl/quaternion_to_euler.sv
`timescale 1ns / 1ps
// quaternion_to_euler: top level, quaternion in, Z-Y-X Euler angles out.
// Depends on qte_pkg, qte_quat_if, qte_euler_if, qte_front, qte_cordic.
//
//   channel  dir  payload                                  transfer when
//   quat     in   quat_w, quat_x, quat_y, quat_z            quat.valid & quat.ready
//   euler    out  roll_angle, pitch_angle, yaw_angle        euler.valid & euler.ready
//
// One quaternion per cycle while euler is not stalled. The pipe holds 4
// front-end stages, three CORDIC pipes of CORDIC_STAGES+1 stages each
// (roll, then pitch, then yaw), one inverse-gain multiply and one output
// register. Roll feeds pitch through the CORDIC magnitude.
// rst is synchronous and clears only the valid bits.
// A stall on euler freezes the whole pipe; quat.ready drops in the same
// cycle, so no transfer is lost or repeated.
module quaternion_to_euler import qte_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int ANGLE_BITS     = 16,
  parameter int CORDIC_STAGES  = 16
) (
  input logic       clk,
  input logic       rst,
  qte_quat_if.sink  quat,
  qte_euler_if.source euler
);

  // rounding from Q2.29 to Q2.(ANGLE_BITS-3)
  localparam int    SH       = ACC_FRAC - (ANGLE_BITS - 3);
  localparam longint HALF    = (SH > 0) ? (64'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 64'sd0;
  localparam longint LIM_PI  = (64'sd1686629713 + HALF) >>> SH;
  localparam longint LIM_PI2 = (64'sd843314856 + HALF) >>> SH;
  localparam logic signed [ZW:0] HALF_W    = (ZW+1)'(HALF);
  localparam logic signed [ZW:0] LIM_PI_W  = (ZW+1)'(LIM_PI);
  localparam logic signed [ZW:0] LIM_PI2_W = (ZW+1)'(LIM_PI2);

  logic en;
  logic out_valid;

  // whole pipe advances when the output register is free or being drained
  assign en          = !out_valid || euler.ready;
  assign quat.ready  = en;
  assign euler.valid = out_valid;

  // front end: matrix terms normalized to a 40-bit sum of squares
  logic                       f_valid;
  logic signed [CORDIC_W-1:0] m21, m22, m20, m10, m00;

  qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid (quat.valid && en),
    .quat_w   (quat.quat_w),
    .quat_x   (quat.quat_x),
    .quat_y   (quat.quat_y),
    .quat_z   (quat.quat_z),
    .out_valid(f_valid),
    .m21, .m22, .m20, .m10, .m00
  );

  // roll = atan2(m21, m22); magnitude feeds pitch
  localparam int RSB = 3 * CORDIC_W;
  logic                       r_valid;
  logic signed [CORDIC_W-1:0] r_mag;
  logic signed [ZW-1:0]       r_z;
  logic [RSB-1:0]             r_side;

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_BITS(RSB)) u_roll (
    .clk, .rst, .en,
    .in_valid(f_valid),
    .in_x    (m22),
    .in_y    (m21),
    .in_side ({m20, m10, m00}),
    .out_valid(r_valid),
    .out_x   (r_mag),
    .out_z   (r_z),
    .out_side(r_side)
  );

  // inverse CORDIC gain on the magnitude, negate m20
  logic                        g_valid;
  logic signed [CORDIC_W-1:0]  g_r, g_ny, g_m10, g_m00;
  logic signed [ZW-1:0]        g_roll;
  logic [CORDIC_W+19:0]        g_prod;
  logic signed [CORDIC_W-1:0]  r_m20;

  assign r_m20  = r_side[RSB-1 -: CORDIC_W];
  assign g_prod = (CORDIC_W+20)'(unsigned'(r_mag)) * (CORDIC_W+20)'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      g_r    <= g_prod[CORDIC_W+INV_GAIN_FRAC-1:INV_GAIN_FRAC];
      g_ny   <= -r_m20;
      g_m10  <= r_side[2*CORDIC_W-1 -: CORDIC_W];
      g_m00  <= r_side[CORDIC_W-1:0];
      g_roll <= r_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= r_valid;
    end
  end

  // pitch = atan2(-m20, |(m21, m22)|)
  localparam int PSB = ZW + 2 * CORDIC_W;
  logic                 p_valid;
  logic signed [ZW-1:0] p_z;
  logic [PSB-1:0]       p_side;

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_BITS(PSB)) u_pitch (
    .clk, .rst, .en,
    .in_valid(g_valid),
    .in_x    (g_r),
    .in_y    (g_ny),
    .in_side ({g_roll, g_m10, g_m00}),
    .out_valid(p_valid),
    .out_x   (),
    .out_z   (p_z),
    .out_side(p_side)
  );

  // yaw = atan2(m10, m00)
  logic                 y_valid;
  logic signed [ZW-1:0] y_z;
  logic [2*ZW-1:0]      y_side;

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_BITS(2*ZW)) u_yaw (
    .clk, .rst, .en,
    .in_valid(p_valid),
    .in_x    (p_side[CORDIC_W-1:0]),
    .in_y    (p_side[2*CORDIC_W-1 -: CORDIC_W]),
    .in_side ({p_side[PSB-1 -: ZW], p_z}),
    .out_valid(y_valid),
    .out_x   (),
    .out_z   (y_z),
    .out_side(y_side)
  );

  // round half up, then clamp the residual CORDIC overshoot
  function automatic logic signed [ZW:0] round_angle(input logic signed [ZW-1:0] z,
                                                     input logic signed [ZW:0] lim);
    logic signed [ZW:0] v;
    v = ((ZW+1)'(z) + HALF_W) >>> SH;
    if (v > lim)  v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  logic signed [ZW:0]           roll_r, pitch_r, yaw_r;
  logic signed [ANGLE_BITS-1:0] roll_q, yaw_q;
  logic signed [ANGLE_BITS-2:0] pitch_q;

  assign roll_r  = round_angle(y_side[2*ZW-1 -: ZW], LIM_PI_W);
  assign pitch_r = round_angle(y_side[ZW-1:0], LIM_PI2_W);
  assign yaw_r   = round_angle(y_z, LIM_PI_W);

  always_ff @(posedge clk) begin
    if (en) begin
      roll_q  <= roll_r[ANGLE_BITS-1:0];
      pitch_q <= pitch_r[ANGLE_BITS-2:0];
      yaw_q   <= yaw_r[ANGLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= y_valid;
    end
  end

  assign euler.roll_angle  = roll_q;
  assign euler.pitch_angle = pitch_q;
  assign euler.yaw_angle   = yaw_q;

  // angles never leave their clamp ranges
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> (roll_q <= LIM_PI) && (roll_q >= -LIM_PI))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> (pitch_q <= LIM_PI2) && (pitch_q >= -LIM_PI2))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> (yaw_q <= LIM_PI) && (yaw_q >= -LIM_PI))
    else $error("yaw out of range");

  // a pipe just out of reset holds no result
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !y_valid && !f_valid)
    else $error("valid bit survived reset");

endmodule
